### rtl/core/lods_pkg.sv
// shared types, register indexes and constants for the lidar detour sequencer
`timescale 1ns / 1ps
`default_nettype none

package lods_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_SIDE      = 3'd1;
  localparam logic [2:0] REG_ADVANCE   = 3'd2;
  localparam logic [2:0] REG_SPEED     = 3'd3;
  localparam logic [2:0] REG_SCAN_LEN  = 3'd4;

  // register reset values
  localparam logic [15:0] THRESHOLD_RST = 16'd250;
  localparam logic [15:0] SIDE_RST      = 16'd20;
  localparam logic [15:0] ADVANCE_RST   = 16'd20;
  localparam logic [10:0] SPEED_RST     = 11'd300;
  localparam int          ScanLenRst    = 360;

  // speed ceiling in mm/s
  localparam logic [10:0] SPEED_LIMIT = 11'd2000;

  // floor(x / 18) = (x * 7282) >> 17 for x below 8192
  localparam logic [12:0] RECIP_18   = 13'd7282;
  localparam int          RecipShift = 17;

  // mode codes on the result stream
  localparam logic [2:0] CODE_FWD     = 3'd0;
  localparam logic [2:0] CODE_RIGHT   = 3'd1;
  localparam logic [2:0] CODE_ADVANCE = 3'd2;
  localparam logic [2:0] CODE_LEFT    = 3'd3;
  localparam logic [2:0] CODE_RETURN  = 3'd4;

  // detour sequencer states
  typedef enum logic [4:0] {
    MODE_FWD     = 5'b00001,
    MODE_RIGHT   = 5'b00010,
    MODE_ADVANCE = 5'b00100,
    MODE_LEFT    = 5'b01000,
    MODE_RETURN  = 5'b10000
  } mode_t;

  // live configuration with the precomputed front window
  typedef struct packed {
    logic [15:0] threshold_mm;
    logic [15:0] side_ticks;
    logic [15:0] advance_ticks;
    logic [10:0] speed_mm_s;
    logic [12:0] win_lo;
    logic [12:0] win_hi;
  } cfg_t;

  // one velocity command from the sequencer
  typedef struct packed {
    logic signed [11:0] vel_x;
    logic signed [11:0] vel_y;
    logic [2:0]         mode;
  } cmd_t;

  // state to mode code
  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] c;
    case (m)
      MODE_FWD:     c = CODE_FWD;
      MODE_RIGHT:   c = CODE_RIGHT;
      MODE_ADVANCE: c = CODE_ADVANCE;
      MODE_LEFT:    c = CODE_LEFT;
      MODE_RETURN:  c = CODE_RETURN;
      default:      c = CODE_FWD;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/lods_cfg.sv
// configuration registers and front window bounds
`timescale 1ns / 1ps
`default_nettype none

module lods_cfg #(
  parameter int MAX_SCAN_POINTS = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wr_en,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_wdata,
  output lods_pkg::cfg_t     cfg
);
  import lods_pkg::*;

  localparam int RstLen = (ScanLenRst > MAX_SCAN_POINTS) ? MAX_SCAN_POINTS : ScanLenRst;
  localparam int RstLo  = RstLen / 2 - RstLen / 18;
  localparam int RstHi  = RstLen / 2 + RstLen / 18;

  logic [12:0] len_raw;
  logic [12:0] len_sat;
  logic [25:0] prod;
  logic [8:0]  half;
  logic [11:0] centre;
  logic [12:0] lo_next;
  logic [12:0] hi_next;
  logic [10:0] spd_raw;
  logic [10:0] spd_next;

  // window bounds from the written scan length
  always_comb begin
    len_raw = cfg_wdata[12:0];
    if (32'(len_raw) > MAX_SCAN_POINTS) begin
      len_sat = 13'(MAX_SCAN_POINTS);
    end else begin
      len_sat = len_raw;
    end
    prod    = len_sat * RECIP_18;
    half    = prod[RecipShift +: 9];
    centre  = len_sat[12:1];
    lo_next = {1'b0, centre} - {4'b0, half};
    hi_next = {1'b0, centre} + {4'b0, half};
  end

  // speed clamp
  always_comb begin
    spd_raw = cfg_wdata[10:0];
    if (spd_raw > SPEED_LIMIT) begin
      spd_next = SPEED_LIMIT;
    end else begin
      spd_next = spd_raw;
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_mm  <= THRESHOLD_RST;
      cfg.side_ticks    <= SIDE_RST;
      cfg.advance_ticks <= ADVANCE_RST;
      cfg.speed_mm_s    <= SPEED_RST;
      cfg.win_lo        <= 13'(RstLo);
      cfg.win_hi        <= 13'(RstHi);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_THRESHOLD: cfg.threshold_mm  <= cfg_wdata;
        REG_SIDE:      cfg.side_ticks    <= cfg_wdata;
        REG_ADVANCE:   cfg.advance_ticks <= cfg_wdata;
        REG_SPEED:     cfg.speed_mm_s    <= spd_next;
        REG_SCAN_LEN: begin
          cfg.win_lo <= lo_next;
          cfg.win_hi <= hi_next;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/lods_win.sv
// running minimum over the front window and per-scan commit
`timescale 1ns / 1ps
`default_nettype none

module lods_win #(
  parameter logic [15:0] CLEAR_RANGE_MM = 16'd10000
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         sample_en,
  input  wire logic [15:0]  range_mm,
  input  wire logic         sample_ok,
  input  wire logic [11:0]  sample_index,
  input  wire logic         scan_end,
  input  wire logic [12:0]  win_lo,
  input  wire logic [12:0]  win_hi,
  output logic      [15:0]  nearest_mm
);

  logic [15:0] running_min;
  logic [15:0] running_min_next;
  logic        in_window;

  // candidate minimum including this sample
  always_comb begin
    in_window = ({1'b0, sample_index} >= win_lo) && ({1'b0, sample_index} < win_hi);
    if (sample_ok && in_window && (range_mm < running_min)) begin
      running_min_next = range_mm;
    end else begin
      running_min_next = running_min;
    end
  end

  // update and commit at scan end
  always_ff @(posedge clk) begin
    if (rst) begin
      running_min <= CLEAR_RANGE_MM;
      nearest_mm  <= CLEAR_RANGE_MM;
    end else if (sample_en) begin
      if (scan_end) begin
        nearest_mm  <= running_min_next;
        running_min <= CLEAR_RANGE_MM;
      end else begin
        running_min <= running_min_next;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/lods_seq.sv
// five-mode detour sequencer run once per control tick
`timescale 1ns / 1ps
`default_nettype none

module lods_seq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           tick_en,
  input  wire lods_pkg::cfg_t cfg,
  input  wire logic [15:0]    nearest_mm,
  output lods_pkg::cmd_t      cmd
);
  import lods_pkg::*;

  mode_t       mode;
  mode_t       mode_next;
  logic [15:0] phase_ticks;
  logic [15:0] phase_ticks_next;
  logic [15:0] phase_inc;
  logic [15:0] limit;
  logic signed [11:0] spd;

  always_comb begin
    spd = signed'({1'b0, cfg.speed_mm_s});
    if (phase_ticks == 16'hFFFF) begin
      phase_inc = phase_ticks;
    end else begin
      phase_inc = phase_ticks + 16'd1;
    end
    if (mode == MODE_ADVANCE) begin
      limit = cfg.advance_ticks;
    end else begin
      limit = cfg.side_ticks;
    end
  end

  // next state and velocity
  always_comb begin
    mode_next        = mode;
    phase_ticks_next = phase_ticks;
    cmd.vel_x        = 12'sd0;
    cmd.vel_y        = 12'sd0;
    case (mode)
      MODE_FWD: begin
        if (nearest_mm < cfg.threshold_mm) begin
          mode_next        = MODE_RIGHT;
          phase_ticks_next = 16'd0;
        end else begin
          cmd.vel_x = spd;
        end
      end
      MODE_RIGHT, MODE_ADVANCE, MODE_LEFT: begin
        if (phase_inc < limit) begin
          phase_ticks_next = phase_inc;
          if (mode == MODE_RIGHT) begin
            cmd.vel_y = spd;
          end else if (mode == MODE_ADVANCE) begin
            cmd.vel_x = spd;
          end else begin
            cmd.vel_y = -spd;
          end
        end else begin
          phase_ticks_next = 16'd0;
          if (mode == MODE_RIGHT) begin
            mode_next = MODE_ADVANCE;
          end else if (mode == MODE_ADVANCE) begin
            mode_next = MODE_LEFT;
          end else begin
            mode_next = MODE_RETURN;
          end
        end
      end
      MODE_RETURN: begin
        cmd.vel_x = spd;
        if (nearest_mm > cfg.threshold_mm) begin
          mode_next = MODE_FWD;
        end
      end
      default: begin
        mode_next        = MODE_FWD;
        phase_ticks_next = 16'd0;
      end
    endcase
    cmd.mode = mode_code(mode_next);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_FWD;
      phase_ticks <= 16'd0;
    end else if (tick_en) begin
      mode        <= mode_next;
      phase_ticks <= phase_ticks_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lidar_obstacle_detour_sequencer.sv
// top level of the lidar front-obstacle detour sequencer
//
// usage:
//   the slave stream carries two kinds of request, chosen by s_axis_tuser:
//   0 is a lidar range sample, 1 is a control tick. s_axis_tlast marks the
//   last sample of a scan and commits the front-window minimum.
//   each tick gives one request on the master stream with the x/y velocity,
//   the mode after the tick and the committed nearest distance; samples give
//   nothing on the master side.
//   an accepted tick is held in the input register and its result is then
//   captured in the result register, which drives the master stream.
//   throughput: one request per cycle, set by the input register feeding
//   the single-pass window and sequencer logic into the result register.
//   when the receiver stalls, the result register holds; one more request
//   waits in the input register, and samples keep flowing past a stalled
//   result since they need no slot on the master side.
//   reset (rst, synchronous) restores register defaults, forward mode and
//   clears both minimum registers to the clear range; no clearing pass.
//   configuration is written through cfg_wr_en/cfg_index/cfg_wdata while idle.
`timescale 1ns / 1ps
`default_nettype none

module lidar_obstacle_detour_sequencer #(
  parameter int          MAX_SCAN_POINTS = 4096,
  parameter logic [15:0] CLEAR_RANGE_MM  = 16'd10000
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // range_mm[15:0], sample_ok[16], sample_index[28:17]
  input  wire logic        s_axis_tlast,  // scan_end
  input  wire logic        s_axis_tuser,  // command
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata   // vel_x[11:0], vel_y[23:12], mode[26:24],
                                          // nearest_mm[42:27]
);
  import lods_pkg::*;

  cfg_t        cfg;
  cmd_t        cmd;
  logic [15:0] nearest_mm;

  // input register
  logic        in_valid;
  logic        in_command;
  logic [15:0] in_range;
  logic        in_ok;
  logic [11:0] in_index;
  logic        in_last;
  logic        advance;
  logic        tick_en;
  logic        sample_en;

  // result register
  logic signed [11:0] out_vel_x;
  logic signed [11:0] out_vel_y;
  logic [2:0]         out_mode;
  logic [15:0]        out_nearest;

  // the held request moves on when it is a sample or the result slot frees
  always_comb begin
    advance       = in_valid && (!in_command || !m_axis_tvalid || m_axis_tready);
    tick_en       = advance && in_command;
    sample_en     = advance && !in_command;
    s_axis_tready = !in_valid || advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_command <= s_axis_tuser;
      in_range   <= s_axis_tdata[15:0];
      in_ok      <= s_axis_tdata[16];
      in_index   <= s_axis_tdata[28:17];
      in_last    <= s_axis_tlast;
    end
  end

  lods_cfg #(
    .MAX_SCAN_POINTS (MAX_SCAN_POINTS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lods_win #(
    .CLEAR_RANGE_MM (CLEAR_RANGE_MM)
  ) u_win (
    .clk          (clk),
    .rst          (rst),
    .sample_en    (sample_en),
    .range_mm     (in_range),
    .sample_ok    (in_ok),
    .sample_index (in_index),
    .scan_end     (in_last),
    .win_lo       (cfg.win_lo),
    .win_hi       (cfg.win_hi),
    .nearest_mm   (nearest_mm)
  );

  lods_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .tick_en    (tick_en),
    .cfg        (cfg),
    .nearest_mm (nearest_mm),
    .cmd        (cmd)
  );

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (tick_en) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (tick_en) begin
      out_vel_x   <= cmd.vel_x;
      out_vel_y   <= cmd.vel_y;
      out_mode    <= cmd.mode;
      out_nearest <= nearest_mm;
    end
  end

  assign m_axis_tdata = {5'b0, out_nearest, out_mode, out_vel_y, out_vel_x};

endmodule

`default_nettype wire

### rtl/core/lods_checker.sv
// port-level checks for the detour sequencer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module lods_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // nothing offered right after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // mode code stays within the five modes
  a_mode: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[26:24] == 3'd0 || m_axis_tdata[26:24] == 3'd1 ||
                       m_axis_tdata[26:24] == 3'd2 || m_axis_tdata[26:24] == 3'd3 ||
                       m_axis_tdata[26:24] == 3'd4))
    else $error("mode code out of range");

  // never a diagonal command
  a_axis: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[11:0] == 12'd0 || m_axis_tdata[23:12] == 12'd0))
    else $error("both velocity components nonzero");

  // sideways modes never drive forward
  a_side: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[26:24] == 3'd1 || m_axis_tdata[26:24] == 3'd3)
      |-> m_axis_tdata[11:0] == 12'd0)
    else $error("forward velocity in a sideways mode");

endmodule

bind lidar_obstacle_detour_sequencer lods_checker u_lods_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
